// File: rtl/udiv_pkg.sv
`default_nettype none

package udiv_pkg;

  // Default operand width of the divider.
  localparam int unsigned DivWidth = 64;

  // Signals handed from one bit cell to the next higher one.
  typedef struct packed {
    logic rem;  // remainder bit (shifts up one place per step)
    logic quo;  // dividend / quotient bit (shifts up one place per step)
    logic brw;  // borrow of the trial subtraction
  } link_t;

endpackage

`default_nettype wire

// File: rtl/udiv_cell.sv
`default_nettype none

module udiv_cell
  import udiv_pkg::*;
(
  input  wire        clk_i,
  input  wire        load_i,
  input  wire        step_i,
  input  wire        dvd_bit_i,
  input  wire        dvs_bit_i,
  input  wire        fits_i,
  input  wire link_t link_i,
  output link_t      link_o
);

  logic rem_q, rem_d;
  logic quo_q, quo_d;
  logic dvs_q, dvs_d;
  logic shift_in;
  logic diff;

  always_comb begin
    shift_in    = link_i.rem;
    diff        = shift_in ^ dvs_q ^ link_i.brw;
    link_o.brw  = (~shift_in & dvs_q) | (~(shift_in ^ dvs_q) & link_i.brw);
    link_o.rem  = rem_q;
    link_o.quo  = quo_q;

    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    if (load_i) begin
      rem_d = 1'b0;
      quo_d = dvd_bit_i;
      dvs_d = dvs_bit_i;
    end else if (step_i) begin
      // keep the difference only when the divisor fits
      rem_d = fits_i ? diff : shift_in;
      quo_d = link_i.quo;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

endmodule

`default_nettype wire

// File: rtl/unsigned_divider_64.sv
`default_nettype none

// Unsigned restoring divider, quotient and remainder of Width-bit operands.
//
// Issue a transaction by raising start_i with dividend_i and divisor_i while
// busy_o is low; it is taken at that clock edge. The operands are held in a
// row of Width bit cells, one bit of remainder, dividend/quotient and divisor
// each. While busy_o is high, every cycle the row shifts one place and does one
// trial subtraction whose borrow ripples from cell to cell, so one quotient bit
// comes out per cycle, Width bits in all.
// The result is shown for exactly one cycle with valid_o high. busy_o drops
// during that cycle, so a new transaction may be issued then, but none is taken
// before the previous one is done. The receiver cannot stall; it must take the
// result while valid_o is high.
// A zero divisor gives an all-ones quotient, the dividend as remainder and
// divide_by_zero_o high. Reset clears busy_o and valid_o; the data path has
// no reset.
module unsigned_divider_64
  import udiv_pkg::*;
#(
  parameter int unsigned Width = DivWidth
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  output logic              busy_o,
  input  wire  [Width-1:0]  dividend_i,
  input  wire  [Width-1:0]  divisor_i,
  output logic              valid_o,
  output logic [Width-1:0]  quotient_o,
  output logic [Width-1:0]  remainder_o,
  output logic              divide_by_zero_o
);

  localparam int unsigned CntW = (Width > 2) ? $clog2(Width) : 1;
  localparam logic [CntW-1:0] LastStep = CntW'(Width - 1);

  logic            busy_q, busy_d;
  logic            valid_q, valid_d;
  logic            dbz_q, dbz_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            load;
  logic            fits;

  link_t link_in  [Width];
  link_t link_out [Width];

  assign load = start_i && !busy_q;

  // the top cell's shifted-out bit and final borrow decide the quotient bit
  assign fits = link_out[Width-1].rem | ~link_out[Width-1].brw;

  always_comb begin
    link_in[0].rem = link_out[Width-1].quo;
    link_in[0].quo = fits;
    link_in[0].brw = 1'b0;
    for (int unsigned i = 1; i < Width; i++) begin
      link_in[i] = link_out[i-1];
    end
  end

  for (genvar i = 0; i < Width; i++) begin : g_cell
    udiv_cell u_cell (
      .clk_i     (clk_i),
      .load_i    (load),
      .step_i    (busy_q),
      .dvd_bit_i (dividend_i[i]),
      .dvs_bit_i (divisor_i[i]),
      .fits_i    (fits),
      .link_i    (link_in[i]),
      .link_o    (link_out[i])
    );
  end

  always_comb begin
    busy_d  = busy_q;
    valid_d = 1'b0;
    cnt_d   = cnt_q;
    dbz_d   = dbz_q;
    if (load) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dbz_d  = (divisor_i == '0);
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d  = 1'b0;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      cnt_q   <= '0;
      dbz_q   <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      dbz_q   <= dbz_d;
    end
  end

  always_comb begin
    for (int unsigned i = 0; i < Width; i++) begin
      quotient_o[i]  = link_out[i].quo;
      remainder_o[i] = link_out[i].rem;
    end
  end

  assign busy_o           = busy_q;
  assign valid_o          = valid_q;
  assign divide_by_zero_o = dbz_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after accepted transaction");

  a_last_step_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == LastStep) |=> (valid_o && !busy_o))
    else $error("result not strobed after last step");

  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("result strobed while busy");

  a_dbz_quotient: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && divide_by_zero_o) |-> (quotient_o == '1))
    else $error("divide by zero without all-ones quotient");

endmodule

`default_nettype wire
